// File: sv/mab_pkg.sv
`timescale 1ns / 1ps
package mab_pkg;

  // Field widths and fixed values of the sample path
  localparam int SAMPLE_W        = 12;
  localparam int SAMPLE_MAX      = 4095;
  localparam int MIDSCALE        = 2048;
  localparam int DEF_RING_DEPTH  = 32;
  localparam int WLEN_W          = 6;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 12;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BIPOLAR_MODE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BRACKET_WIDTH = 2'd2;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_DIVIDE,
    ST_DELIVER
  } st_t;

  // Divider control and status
  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// File: sv/mab_serial_div.sv
`timescale 1ns / 1ps
module mab_serial_div import mab_pkg::*; #(
  parameter int DVD_W = 17,
  parameter int DVS_W = 6
) (
  input  logic             clk,
  input  logic             rst_n,
  input  div_ctrl_t        ctrl,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output div_stat_t        stat,
  output logic [DVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] dvd_r, dvd_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVS_W-1:0] dvs_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DVS_W:0]   shifted;
  logic [DVS_W+1:0] trial;

  // One restoring step per cycle: dividend bits shift out at the top,
  // quotient bits shift in at the bottom of the same register
  always_comb begin
    shifted  = {rem_r, dvd_r[DVD_W-1]};
    trial    = {1'b0, shifted} - {2'b00, dvs_r};
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (ctrl.start) begin
      dvd_nxt  = dividend;
      rem_nxt  = '0;
      cnt_nxt  = CNT_W'(DVD_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[DVS_W+1]) begin
        rem_nxt = trial[DVS_W-1:0];
        dvd_nxt = {dvd_r[DVD_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[DVS_W-1:0];
        dvd_nxt = {dvd_r[DVD_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    if (ctrl.start) begin
      dvs_r <= divisor;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = dvd_r;

endmodule

// File: sv/moving_average_with_bracket.sv
`timescale 1ns / 1ps
// Channel   Dir  Handshake          Payload
// in_       in   in_valid/in_stall  in_sample_in[11:0]
// out_      out  out_valid/out_stall out_average_out[11:0], out_held_out[11:0]
// cfg_      in   cfg_we             cfg_index[1:0], cfg_data[11:0]
//
// A word's result reaches the output register after the sum update, SUM_W
// divider steps, the divider's done flag and the load of the output; the next
// word is taken once the sequencer has returned to idle, so no word is taken
// while the one before it is still in work.
// Reset is synchronous; the ring preset is done by clearing per-entry valid
// flags at once, so no clearing pass follows reset or a config write.
// in_stall is high while a word is in work; the next word is taken while a
// result still waits in the output register, then holds in the deliver step.
module moving_average_with_bracket import mab_pkg::*; #(
  parameter int RING_DEPTH = DEF_RING_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [SAMPLE_W-1:0]   in_sample_in,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [SAMPLE_W-1:0]   out_average_out,
  output logic [SAMPLE_W-1:0]   out_held_out,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int POS_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int LEN_W = $clog2(RING_DEPTH + 1);
  localparam int SUM_W = SAMPLE_W + $clog2(RING_DEPTH);
  localparam int ARI_W = SAMPLE_W + 2;
  localparam int MID_SH = $clog2(MIDSCALE);

  st_t state_r, state_nxt;

  logic [WLEN_W-1:0]   wlen_r, wlen_nxt;
  logic                bip_r, bip_nxt;
  logic [SAMPLE_W-1:0] bw_r, bw_nxt;
  logic                preset;

  logic [SAMPLE_W-1:0] ring_mem [RING_DEPTH];
  logic [RING_DEPTH-1:0] vld_r;
  logic [SAMPLE_W-1:0] rd_r;
  logic [SAMPLE_W-1:0] smp_r;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [SAMPLE_W-1:0] held_r;

  logic                out_valid_r;
  logic [SAMPLE_W-1:0] avg_out_r, held_out_r;

  logic [LEN_W-1:0]    eff_len, eff_len_new;
  logic [SAMPLE_W-1:0] pre_val, pre_val_new;
  logic [SAMPLE_W-1:0] old_smp;
  logic [POS_W:0]      pos_inc;

  div_ctrl_t           div_ctrl;
  div_stat_t           div_st;
  logic [SUM_W-1:0]    quo;

  logic                accept, load_out, do_update;
  logic [SAMPLE_W-1:0] avg;
  logic signed [ARI_W-1:0] a_s, h_s, b_s, d_s, hn_s;
  logic [SAMPLE_W-1:0] held_new;

  // Window length clamped to 1..RING_DEPTH
  function automatic logic [LEN_W-1:0] clamp_len(input logic [WLEN_W-1:0] wl);
    logic [LEN_W-1:0] r;
    if (wl == '0) begin
      r = LEN_W'(1);
    end else if (int'(wl) > RING_DEPTH) begin
      r = LEN_W'(RING_DEPTH);
    end else begin
      r = LEN_W'(wl);
    end
    return r;
  endfunction

  // Config decode; an index beyond the list changes nothing
  always_comb begin
    wlen_nxt = wlen_r;
    bip_nxt  = bip_r;
    bw_nxt   = bw_r;
    preset   = 1'b0;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_WINDOW_LENGTH: begin
          wlen_nxt = cfg_data[WLEN_W-1:0];
          preset   = 1'b1;
        end
        CFG_BIPOLAR_MODE: begin
          bip_nxt = cfg_data[0];
          preset  = 1'b1;
        end
        CFG_BRACKET_WIDTH: begin
          bw_nxt = cfg_data;
          preset = 1'b1;
        end
        default: begin
          preset = 1'b0;
        end
      endcase
    end
  end

  assign eff_len     = clamp_len(wlen_r);
  assign eff_len_new = clamp_len(wlen_nxt);
  assign pre_val     = bip_r ? SAMPLE_W'(MIDSCALE) : '0;
  assign pre_val_new = bip_nxt ? SAMPLE_W'(MIDSCALE) : '0;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:    if (in_valid) state_nxt = ST_UPDATE;
      ST_UPDATE:  state_nxt = ST_DIVIDE;
      ST_DIVIDE:  if (div_st.done) state_nxt = ST_DELIVER;
      ST_DELIVER: if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // State machine outputs
  always_comb begin
    in_stall       = 1'b1;
    do_update      = 1'b0;
    load_out       = 1'b0;
    div_ctrl.start = 1'b0;
    unique case (state_r)
      ST_IDLE:    in_stall = 1'b0;
      ST_UPDATE: begin
        do_update      = 1'b1;
        div_ctrl.start = 1'b1;
      end
      ST_DIVIDE:  in_stall = 1'b1;
      ST_DELIVER: load_out = !out_valid_r || !out_stall;
      default:    in_stall = 1'b1;
    endcase
  end

  assign accept = in_valid && !in_stall;

  // Sum update and ring position advance
  always_comb begin
    old_smp = vld_r[pos_r] ? rd_r : pre_val;
    sum_nxt = sum_r - SUM_W'(old_smp) + SUM_W'(smp_r);
    pos_inc = {1'b0, pos_r} + (POS_W+1)'(1);
    if (LEN_W'(pos_inc) >= eff_len) begin
      pos_nxt = '0;
    end else begin
      pos_nxt = pos_inc[POS_W-1:0];
    end
  end

  mab_serial_div #(
    .DVD_W (SUM_W),
    .DVS_W (LEN_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (div_ctrl),
    .dividend (sum_nxt),
    .divisor  (eff_len),
    .stat     (div_st),
    .quotient (quo)
  );

  // Clamp the average and apply the dead band
  always_comb begin
    if (|quo[SUM_W-1:SAMPLE_W]) begin
      avg = SAMPLE_W'(SAMPLE_MAX);
    end else begin
      avg = quo[SAMPLE_W-1:0];
    end
    a_s = signed'({2'b00, avg});
    h_s = signed'({2'b00, held_r});
    b_s = signed'({2'b00, bw_r});
    d_s = a_s - h_s;
    if (d_s > b_s) begin
      hn_s = a_s - b_s;
    end else if (d_s < -b_s) begin
      hn_s = a_s + b_s;
    end else begin
      hn_s = h_s;
    end
    if (hn_s < 0) begin
      held_new = '0;
    end else if (hn_s > ARI_W'(SAMPLE_MAX)) begin
      held_new = SAMPLE_W'(SAMPLE_MAX);
    end else begin
      held_new = hn_s[SAMPLE_W-1:0];
    end
  end

  // Control state, config and block state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wlen_r      <= WLEN_W'(DEF_RING_DEPTH);
      bip_r       <= 1'b0;
      bw_r        <= '0;
      vld_r       <= '0;
      pos_r       <= '0;
      sum_r       <= SUM_W'(clamp_len(WLEN_W'(DEF_RING_DEPTH))) * SUM_W'(0);
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      wlen_r  <= wlen_nxt;
      bip_r   <= bip_nxt;
      bw_r    <= bw_nxt;
      if (preset) begin
        vld_r  <= '0;
        pos_r  <= '0;
        sum_r  <= bip_nxt ? (SUM_W'(eff_len_new) << MID_SH) : '0;
        held_r <= pre_val_new;
      end else begin
        if (do_update) begin
          vld_r[pos_r] <= 1'b1;
          pos_r        <= pos_nxt;
          sum_r        <= sum_nxt;
        end
        if (load_out) begin
          held_r <= held_new;
        end
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Ring memory: read on accept, write during the update
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_r  <= ring_mem[pos_r];
      smp_r <= in_sample_in;
    end
    if (do_update) begin
      ring_mem[pos_r] <= smp_r;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (load_out) begin
      avg_out_r  <= avg;
      held_out_r <= held_new;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_average_out = avg_out_r;
  assign out_held_out    = held_out_r;

  // Checks
  a_out_from_deliver: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DELIVER))
    else $error("result word raised outside the deliver step");

  a_pos_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    (LEN_W'(pos_r) < eff_len))
    else $error("ring position outside the window");

  a_div_done_in_divide: assert property (@(posedge clk) disable iff (!rst_n)
    div_st.done |-> (state_r == ST_DIVIDE))
    else $error("divider finished outside the divide step");

  a_no_start_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    div_ctrl.start |-> !div_st.busy)
    else $error("divider restarted while busy");

endmodule
